/* rtl/cea_pkg.sv */
// ----------------------------------------------------------------------------
// cea_pkg: shared definitions of the compression estimate accumulator
// Field widths, reset values, parameter defaults and the control word that
// travels with each item through the pipeline.
// ----------------------------------------------------------------------------
package cea_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned DICT_W     = 16;
  localparam int unsigned LOG_SUM_W  = 48;
  localparam int unsigned SQ_SUM_W   = 56;
  localparam int unsigned TESTED_W   = 24;

  // Defaults for the top-level parameters.
  localparam int unsigned BLOCK_BITS_DEF    = 6;
  localparam int unsigned POSITION_BITS_DEF = 24;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Dictionary length after reset.
  localparam logic [DICT_W-1:0] DICT_RESET = 16'd1000;

  // Saturation limits.
  localparam logic [LOG_SUM_W-1:0] LOG_SUM_MAX = '1;
  localparam logic [SQ_SUM_W-1:0]  SQ_SUM_MAX  = '1;
  localparam logic [TESTED_W-1:0]  TESTED_MAX  = '1;

  // Control word of one pipeline slot.
  typedef struct packed {
    logic                blk;      // slot carries a tested block
    logic                last;     // slot closes the data set
    logic                too_few;  // data set had too few blocks
    logic [TESTED_W-1:0] tested;   // tested block count of the data set
  } ctl_t;

endpackage

/* rtl/cea_if.sv */
// ----------------------------------------------------------------------------
// cea_if: channel interfaces of the compression estimate accumulator
// Sample input channel, result output channel and configuration channel,
// each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface cea_in_if;
  import cea_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                last_sample;
  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface cea_out_if;
  import cea_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [LOG_SUM_W-1:0] log_sum;
  logic [SQ_SUM_W-1:0]  square_sum;
  logic [TESTED_W-1:0]  tested_blocks;
  logic                 too_few;
  modport source (output valid, log_sum, square_sum, tested_blocks, too_few, input ready);
  modport sink   (input valid, log_sum, square_sum, tested_blocks, too_few, output ready);
endinterface

interface cea_cfg_if;
  import cea_pkg::*;
  logic              valid;
  logic              ready;
  logic [DICT_W-1:0] dictionary_blocks;
  modport source (output valid, dictionary_blocks, input ready);
  modport sink   (input valid, dictionary_blocks, output ready);
endinterface

/* rtl/cea_ram.sv */
// ----------------------------------------------------------------------------
// cea_ram: generic simple dual-port RAM
// One write port and one read port with registered, read-first output.
// ----------------------------------------------------------------------------
module cea_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cea_front.sv */
// ----------------------------------------------------------------------------
// cea_front: block packing and last-seen table
// Packs sample bits into blocks, counts block positions, and looks up and
// updates the position at which each block value was last seen.
// ----------------------------------------------------------------------------
module cea_front #(
  parameter int unsigned BLOCK_BITS    = 6,
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             in_valid_i,
  input  logic                             bit_i,
  input  logic                             last_i,
  input  logic [cea_pkg::DICT_W-1:0]       dict_i,
  output cea_pkg::ctl_t                    ctl_o,
  output logic [POSITION_BITS-1:0]         pos_o,
  output logic [POSITION_BITS-1:0]         last_seen_o
);

  import cea_pkg::*;

  localparam int unsigned DEPTH = 1 << BLOCK_BITS;
  localparam int unsigned CNT_W = (BLOCK_BITS > 1) ? $clog2(BLOCK_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_BITS - 1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [BLOCK_BITS-1:0]    shift_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [POSITION_BITS-1:0] pos_q;
  logic [DEPTH-1:0]         vld_q;

  logic                     accept;
  logic [BLOCK_BITS:0]      shift_ext;
  logic [BLOCK_BITS-1:0]    value;
  logic                     blk_ok;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [POSITION_BITS-1:0] pos_after;
  logic [POSITION_BITS-1:0] dict_ext;
  logic [POSITION_BITS-1:0] diff;
  logic                     too_few;
  logic [TESTED_W-1:0]      tested;
  logic [POSITION_BITS-1:0] rd_data;

  ctl_t                     ctl_q;
  logic [POSITION_BITS-1:0] pos1_q;
  logic                     seen_q;

  assign accept    = en_i & in_valid_i;
  assign shift_ext = {shift_q, bit_i};
  assign value     = shift_ext[BLOCK_BITS-1:0];
  assign blk_ok    = accept && (cnt_q == CNT_LAST) && (pos_q != POS_MAX);
  assign pos_inc   = pos_q + POSITION_BITS'(1);
  assign pos_after = blk_ok ? pos_inc : pos_q;
  assign dict_ext  = POSITION_BITS'(dict_i);
  assign too_few   = (pos_after <= dict_ext);
  assign diff      = pos_after - dict_ext;

  always_comb begin
    if (too_few) begin
      tested = '0;
    end else if (diff > POSITION_BITS'(TESTED_MAX)) begin
      tested = TESTED_MAX;
    end else begin
      tested = TESTED_W'(diff);
    end
  end

  cea_ram #(
    .WIDTH (POSITION_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (blk_ok),
    .waddr_i (value),
    .wdata_i (pos_inc),
    .re_i    (en_i),
    .raddr_i (value),
    .rdata_o (rd_data)
  );

  // Packing state, position counter and the table's valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
      vld_q   <= '0;
    end else if (accept) begin
      if (last_i) begin
        shift_q <= '0;
        cnt_q   <= '0;
        pos_q   <= '0;
        vld_q   <= '0;
      end else if (cnt_q == CNT_LAST) begin
        shift_q <= '0;
        cnt_q   <= '0;
        pos_q   <= pos_after;
        if (blk_ok) begin
          vld_q[value] <= 1'b1;
        end
      end else begin
        shift_q <= value;
        cnt_q   <= cnt_q + CNT_W'(1);
      end
    end
  end

  // Stage register alongside the table read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q.blk     <= blk_ok && (pos_inc > dict_ext);
      ctl_q.last    <= accept && last_i;
      ctl_q.too_few <= too_few;
      ctl_q.tested  <= tested;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos1_q <= pos_inc;
      seen_q <= vld_q[value];
    end
  end

  assign ctl_o       = ctl_q;
  assign pos_o       = pos1_q;
  assign last_seen_o = seen_q ? rd_data : '0;

endmodule

/* rtl/cea_log2.sv */
// ----------------------------------------------------------------------------
// cea_log2: pipelined fixed-point log2 of the block distance and its square
// Distance, integer part, normalization, one squaring stage per fraction
// bit plus one for rounding, rounding and squaring, each behind a register.
// ----------------------------------------------------------------------------
module cea_log2 #(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned FRACTION_BITS = 16,
  localparam int unsigned LW  = FRACTION_BITS + 6,
  localparam int unsigned SQW = FRACTION_BITS + 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  cea_pkg::ctl_t            ctl_i,
  input  logic [POSITION_BITS-1:0] pos_i,
  input  logic [POSITION_BITS-1:0] last_seen_i,
  output cea_pkg::ctl_t            ctl_o,
  output logic [LW-1:0]            l_o,
  output logic [SQW-1:0]           sq_o
);

  import cea_pkg::*;

  localparam int unsigned IT    = FRACTION_BITS + 1;
  localparam int unsigned DEPTH = IT + 5;

  ctl_t ctl_q [DEPTH];

  logic [31:0]            dist_a_q;
  logic [31:0]            dist_b_q;
  logic [4:0]             k_d;
  logic [31:0]            m_q    [IT];
  logic [4:0]             k_q    [IT+1];
  logic [FRACTION_BITS:0] bits_q [IT+1];
  logic [63:0]            prod   [IT];
  logic [31:0]            m_d    [IT];
  logic                   bit_d  [IT];
  logic [FRACTION_BITS+1:0] bits_inc;
  logic [LW-1:0]          l_d;
  logic [LW-1:0]          l_q;
  logic [LW-1:0]          l2_q;
  logic [2*LW-1:0]        l_prod;
  logic [SQW-1:0]         sq_q;

  // Integer part: index of the highest set bit.
  always_comb begin
    k_d = '0;
    for (int b = 0; b < 32; b++) begin
      if (dist_b_q[b]) begin
        k_d = 5'(b);
      end
    end
  end

  // Each stage squares the Q1.31 mantissa; a result of two or more gives
  // a one bit and is halved.
  always_comb begin
    for (int i = 0; i < IT; i++) begin
      prod[i]  = {32'b0, m_q[i]} * {32'b0, m_q[i]};
      bit_d[i] = prod[i][63];
      m_d[i]   = prod[i][63] ? prod[i][63:32] : prod[i][62:31];
    end
  end

  assign bits_inc = {1'b0, bits_q[IT]} + (FRACTION_BITS+2)'(1);
  assign l_d      = LW'({k_q[IT], {FRACTION_BITS{1'b0}}}) + LW'(bits_inc[FRACTION_BITS+1:1]);
  assign l_prod   = l_q * l_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DEPTH; s++) begin
        ctl_q[s] <= '0;
      end
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
      for (int s = 1; s < DEPTH; s++) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_a_q  <= 32'(pos_i - last_seen_i);
      dist_b_q  <= dist_a_q;
      m_q[0]    <= dist_b_q << (5'd31 - k_d);
      k_q[0]    <= k_d;
      bits_q[0] <= '0;
      for (int i = 0; i < IT - 1; i++) begin
        m_q[i+1] <= m_d[i];
      end
      for (int i = 0; i < IT; i++) begin
        k_q[i+1]    <= k_q[i];
        bits_q[i+1] <= {bits_q[i][FRACTION_BITS-1:0], bit_d[i]};
      end
      l_q  <= l_d;
      l2_q <= l_q;
      sq_q <= l_prod[2*LW-1:FRACTION_BITS];
    end
  end

  assign ctl_o = ctl_q[DEPTH-1];
  assign l_o   = l2_q;
  assign sq_o  = sq_q;

endmodule

/* rtl/cea_accum.sv */
// ----------------------------------------------------------------------------
// cea_accum: saturating sums and result register
// Adds each tested block's log2 and square into the running sums and hands
// the sums out when the data set closes.
// ----------------------------------------------------------------------------
module cea_accum #(
  parameter int unsigned FRACTION_BITS = 16,
  localparam int unsigned LW  = FRACTION_BITS + 6,
  localparam int unsigned SQW = FRACTION_BITS + 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cea_pkg::ctl_t                     ctl_i,
  input  logic [LW-1:0]                     l_i,
  input  logic [SQW-1:0]                    sq_i,
  input  logic                              out_ready_i,
  output logic                              en_o,
  output logic                              out_valid_o,
  output logic [cea_pkg::LOG_SUM_W-1:0]     log_sum_o,
  output logic [cea_pkg::SQ_SUM_W-1:0]      square_sum_o,
  output logic [cea_pkg::TESTED_W-1:0]      tested_o,
  output logic                              too_few_o
);

  import cea_pkg::*;

  logic [LOG_SUM_W-1:0] log_q;
  logic [SQ_SUM_W-1:0]  sqs_q;
  logic [LOG_SUM_W:0]   log_add;
  logic [SQ_SUM_W:0]    sqs_add;
  logic [LOG_SUM_W-1:0] log_d;
  logic [SQ_SUM_W-1:0]  sqs_d;
  logic                 out_valid_q;
  logic [LOG_SUM_W-1:0] out_log_q;
  logic [SQ_SUM_W-1:0]  out_sqs_q;
  logic [TESTED_W-1:0]  out_tested_q;
  logic                 out_too_few_q;

  // The pipeline holds only when a second result reaches the end while the
  // previous one has not been taken.
  assign en_o = !(ctl_i.last && out_valid_q && !out_ready_i);

  assign log_add = {1'b0, log_q} + (LOG_SUM_W+1)'(l_i);
  assign sqs_add = {1'b0, sqs_q} + (SQ_SUM_W+1)'(sq_i);

  always_comb begin
    log_d = log_q;
    sqs_d = sqs_q;
    if (ctl_i.blk) begin
      log_d = log_add[LOG_SUM_W] ? LOG_SUM_MAX : log_add[LOG_SUM_W-1:0];
      sqs_d = sqs_add[SQ_SUM_W]  ? SQ_SUM_MAX  : sqs_add[SQ_SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_q       <= '0;
      sqs_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_o) begin
        if (ctl_i.last) begin
          log_q <= '0;
          sqs_q <= '0;
        end else begin
          log_q <= log_d;
          sqs_q <= sqs_d;
        end
      end
      if (en_o && ctl_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && ctl_i.last) begin
      out_log_q     <= log_d;
      out_sqs_q     <= sqs_d;
      out_tested_q  <= ctl_i.tested;
      out_too_few_q <= ctl_i.too_few;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign log_sum_o    = out_log_q;
  assign square_sum_o = out_sqs_q;
  assign tested_o     = out_tested_q;
  assign too_few_o    = out_too_few_q;

endmodule

/* rtl/compression_estimate_accumulator.sv */
// ----------------------------------------------------------------------------
// compression_estimate_accumulator: compression estimate sums of a bit stream
// Packs noise bits into blocks and accumulates the log2 of the distance to
// each block value's previous occurrence, and its square.
// ----------------------------------------------------------------------------
//
// The block takes one sample item per clock cycle and uses only bit zero of
// the sample. Every BLOCK_BITS bits form a block, first bit most significant.
// Blocks are numbered from one; a 2^BLOCK_BITS-entry RAM keeps the number
// of the block at which each block value was last seen, with one valid bit
// per entry so that a new data set starts with an empty table at once. The
// first dictionary_blocks blocks only fill the table. For every later block
// the distance to the previous occurrence goes through a fully pipelined
// fixed-point log2 (one squaring multiplier per fraction bit plus one), and
// the log2 value, rounded to nearest with FRACTION_BITS fraction bits, and
// its truncated square are added into two saturating sums. The item that
// carries last_sample closes the data set: the result item with both sums,
// the tested block count and the too-few flag enters the result register
// once that item has passed the front stage register and the log2 pipeline,
// and all state except dictionary_blocks starts over, so the next data set
// may follow in the very next cycle. Bits of an incomplete final block are
// dropped. Input items are accepted in every cycle; the input only stalls
// when a second result reaches the result register while the previous
// result has not been taken. dictionary_blocks is written through the
// configuration channel, which is always ready, and must only change while
// no data set is in flight.
//
module compression_estimate_accumulator #(
  parameter int unsigned BLOCK_BITS    = cea_pkg::BLOCK_BITS_DEF,
  parameter int unsigned POSITION_BITS = cea_pkg::POSITION_BITS_DEF,
  parameter int unsigned FRACTION_BITS = cea_pkg::FRACTION_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  cea_in_if.sink           in_i,
  cea_out_if.source        out_o,
  cea_cfg_if.sink          cfg_i
);

  import cea_pkg::*;

  localparam int unsigned LW  = FRACTION_BITS + 6;
  localparam int unsigned SQW = FRACTION_BITS + 12;

  logic [DICT_W-1:0]        dict_q;
  logic                     en;
  ctl_t                     front_ctl;
  ctl_t                     log_ctl;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] last_seen;
  logic [LW-1:0]            l_val;
  logic [SQW-1:0]           sq_val;

  // Dictionary length register; the configuration channel never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dict_q <= DICT_RESET;
    end else if (cfg_i.valid) begin
      dict_q <= cfg_i.dictionary_blocks;
    end
  end

  // The whole pipeline advances together; an empty slot is a bubble.
  assign in_i.ready = en;

  cea_front #(
    .BLOCK_BITS    (BLOCK_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_i.valid),
    .bit_i       (in_i.sample[0]),
    .last_i      (in_i.last_sample),
    .dict_i      (dict_q),
    .ctl_o       (front_ctl),
    .pos_o       (pos),
    .last_seen_o (last_seen)
  );

  cea_log2 #(
    .POSITION_BITS (POSITION_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_log2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctl_i       (front_ctl),
    .pos_i       (pos),
    .last_seen_i (last_seen),
    .ctl_o       (log_ctl),
    .l_o         (l_val),
    .sq_o        (sq_val)
  );

  cea_accum #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (log_ctl),
    .l_i          (l_val),
    .sq_i         (sq_val),
    .out_ready_i  (out_o.ready),
    .en_o         (en),
    .out_valid_o  (out_o.valid),
    .log_sum_o    (out_o.log_sum),
    .square_sum_o (out_o.square_sum),
    .tested_o     (out_o.tested_blocks),
    .too_few_o    (out_o.too_few)
  );

endmodule

/* tb/cea_sums_checker.sv */
// ----------------------------------------------------------------------------
// cea_sums_checker: result checker of the compression estimate accumulator
// Watches the sample, configuration and result channels, predicts the sums
// of every data set and compares each result item field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cea_sums_checker (
  input  logic clk_i,
  input  logic rst_ni,
  cea_in_if    in_i,
  cea_out_if   out_i,
  cea_cfg_if   cfg_i,
  output int   fail_count_o,
  output int   pending_o
);

  import cea_pkg::*;

  localparam int unsigned BLK_W  = BLOCK_BITS_DEF;
  localparam int unsigned POS_W  = POSITION_BITS_DEF;
  localparam int unsigned FRAC_W = FRACTION_BITS_DEF;
  localparam logic [63:0] POSITION_LIMIT = (64'd1 << POS_W) - 64'd1;

  typedef struct packed {
    logic [LOG_SUM_W-1:0] log_sum;
    logic [SQ_SUM_W-1:0]  square_sum;
    logic [TESTED_W-1:0]  tested_blocks;
    logic                 too_few;
  } set_totals_t;

  logic [POS_W-1:0]  last_seen [2**BLK_W];
  logic [BLK_W-1:0]  shift_reg;
  int unsigned       bits_in_block;
  logic [63:0]       block_no;
  logic [63:0]       log_acc;
  logic [63:0]       square_acc;
  logic [DICT_W-1:0] dict_blocks;
  set_totals_t       expected_totals [$];
  int                failures;

  // Base-2 logarithm with FRAC_W fraction bits, rounded to nearest. The
  // fraction comes from repeated squaring of the normalized mantissa.
  function automatic logic [63:0] log2_q16(input logic [63:0] n);
    int unsigned k;
    int unsigned i;
    logic [63:0] m;
    logic [63:0] bits;
    k    = 0;
    bits = '0;
    n    = n & 64'hFFFF_FFFF;
    if (n == 0) return '0;
    while (k < 31 && (n >> (k + 1)) != 0) k++;
    m = n << (31 - k);
    for (i = 0; i < FRAC_W + 1; i++) begin
      m    = (m * m) >> 31;
      bits = bits << 1;
      if (m >= (64'd1 << 32)) begin
        bits = bits | 64'd1;
        m    = m >> 1;
      end
    end
    return (64'(k) << FRAC_W) + ((bits + 64'd1) >> 1);
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] limit);
    if (a > limit || b > limit - a) return limit;
    return a + b;
  endfunction

  function automatic void clear_dataset();
    foreach (last_seen[i]) last_seen[i] = '0;
    shift_reg     = '0;
    bits_in_block = 0;
    block_no      = '0;
    log_acc       = '0;
    square_acc    = '0;
  endfunction

  function automatic void close_block(input logic [BLK_W-1:0] value);
    logic [63:0] gap_len;
    logic [63:0] l;
    logic [63:0] sq;
    // Past the last position, blocks are ignored altogether.
    if (block_no >= POSITION_LIMIT) return;
    block_no++;
    if (block_no > dict_blocks) begin
      gap_len    = block_no - last_seen[value];
      l          = log2_q16(gap_len);
      sq         = (l * l) >> FRAC_W;
      log_acc    = sat_add(log_acc, l, 64'(LOG_SUM_MAX));
      square_acc = sat_add(square_acc, sq, 64'(SQ_SUM_MAX));
    end
    last_seen[value] = block_no[POS_W-1:0];
  endfunction

  function automatic void absorb_sample(input logic bit_in, input logic closes_set);
    logic [63:0] tested;
    set_totals_t totals;
    shift_reg = {shift_reg[BLK_W-2:0], bit_in};
    bits_in_block++;
    if (bits_in_block >= BLK_W) begin
      close_block(shift_reg);
      shift_reg     = '0;
      bits_in_block = 0;
    end
    if (closes_set) begin
      tested = (block_no > dict_blocks) ? block_no - dict_blocks : 64'd0;
      if (tested > 64'(TESTED_MAX)) tested = 64'(TESTED_MAX);
      totals.log_sum       = log_acc[LOG_SUM_W-1:0];
      totals.square_sum    = square_acc[SQ_SUM_W-1:0];
      totals.tested_blocks = tested[TESTED_W-1:0];
      totals.too_few       = (block_no <= dict_blocks);
      expected_totals.push_back(totals);
      clear_dataset();
    end
  endfunction

  function automatic void check_result();
    set_totals_t want;
    if (expected_totals.size() == 0) begin
      $error("result item arrived with no data set pending");
      failures++;
      return;
    end
    want = expected_totals.pop_front();
    if (out_i.log_sum !== want.log_sum) begin
      $error("log_sum mismatch: expected %0d, actual %0d", want.log_sum, out_i.log_sum);
      failures++;
    end
    if (out_i.square_sum !== want.square_sum) begin
      $error("square_sum mismatch: expected %0d, actual %0d",
             want.square_sum, out_i.square_sum);
      failures++;
    end
    if (out_i.tested_blocks !== want.tested_blocks) begin
      $error("tested_blocks mismatch: expected %0d, actual %0d",
             want.tested_blocks, out_i.tested_blocks);
      failures++;
    end
    if (out_i.too_few !== want.too_few) begin
      $error("too_few mismatch: expected %0b, actual %0b", want.too_few, out_i.too_few);
      failures++;
    end
  endfunction

  // Results leave the block long after their data set closed, so at each clock
  // edge the result side is handled first.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_dataset();
      dict_blocks = DICT_RESET;
      expected_totals.delete();
      failures     = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_i.valid === 1'b1 && out_i.ready === 1'b1) check_result();
      if (cfg_i.valid === 1'b1 && cfg_i.ready === 1'b1) dict_blocks = cfg_i.dictionary_blocks;
      if (in_i.valid === 1'b1 && in_i.ready === 1'b1) begin
        absorb_sample(in_i.sample[0], in_i.last_sample);
      end
      pending_o    <= expected_totals.size();
      fail_count_o <= failures;
    end
  end

endmodule

/* tb/compression_estimate_accumulator_tb.sv */
// ----------------------------------------------------------------------------
// compression_estimate_accumulator_tb: top of the accumulator testbench
// Drives noise samples and dictionary settings into the block, stalls the
// result side at random and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module compression_estimate_accumulator_tb;
  import cea_pkg::*;

  localparam int unsigned     CLK_PERIOD    = 20;
  localparam int unsigned     RESET_CYCLES  = 10;
  // The result of a data set trails its closing item through the pipeline;
  // this margin covers that with room to spare.
  localparam int unsigned     SETTLE_CYCLES = 40;
  // Length of the long result-side hold-off that fills the block.
  localparam int unsigned     HOLD_CYCLES   = 400;
  localparam int unsigned     PRESSURE_SETS = 80;
  localparam int unsigned     RANDOM_ITEMS  = 1400;
  localparam longint unsigned CYCLE_LIMIT   = 600_000;

  // Shapes of the bit stream inside one data set.
  typedef enum int unsigned {
    PAT_RANDOM,
    PAT_ZEROS,
    PAT_ONES,
    PAT_MOTIF,
    PAT_SPARSE
  } bit_pattern_e;

  logic clk;
  logic rst_n;

  cea_in_if  in_ch ();
  cea_out_if out_ch ();
  cea_cfg_if cfg_ch ();

  int              fail_count;
  int              pending;
  bit              hold_off_req;
  bit              hold_active;
  int unsigned     burst_left;
  int unsigned     random_items;
  longint unsigned cycle_count;

  compression_estimate_accumulator DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  cea_sums_checker sums_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .cfg_i        (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog: a correct run ends far below this limit, so reaching it
  // means the block hung somewhere.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Offers one sample item and returns at the edge where it is accepted.
  // The sender works in bursts; between bursts it idles for a random gap,
  // and about a third of the bursts follow the previous one with no gap.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic closes_set);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= value;
    in_ch.last_sample <= closes_set;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    burst_left--;
  endtask

  // Sends one data set of the given length; only the final item carries
  // last_sample. The upper seven bits of each sample are random noise that
  // the block must ignore; bit zero follows the chosen pattern.
  task automatic send_dataset(input int unsigned length, input bit_pattern_e pattern);
    logic [BLOCK_BITS_DEF-1:0] motif [8];
    logic [BLOCK_BITS_DEF-1:0] blk;
    logic [SAMPLE_W-1:0]       noise;
    int unsigned               motif_len;
    int unsigned               i;
    logic                      b;
    motif_len = $urandom_range(1, 8);
    for (i = 0; i < 8; i++) begin
      motif[i] = BLOCK_BITS_DEF'($urandom_range(0, 2**BLOCK_BITS_DEF - 1));
    end
    for (i = 0; i < length; i++) begin
      case (pattern)
        PAT_ZEROS:  b = 1'b0;
        PAT_ONES:   b = 1'b1;
        PAT_SPARSE: b = ($urandom_range(0, 15) == 0);
        PAT_MOTIF: begin
          // A short cycle of block values gives small, repeating distances.
          blk = motif[(i / BLOCK_BITS_DEF) % motif_len];
          b   = blk[BLOCK_BITS_DEF - 1 - (i % BLOCK_BITS_DEF)];
        end
        default:    b = 1'($urandom_range(0, 1));
      endcase
      noise = SAMPLE_W'($urandom);
      send_sample({noise[SAMPLE_W-1:1], b}, i == length - 1);
    end
  endtask

  function automatic bit_pattern_e pick_pattern();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 7)  return PAT_RANDOM;
    if (roll < 14) return PAT_MOTIF;
    if (roll < 17) return PAT_SPARSE;
    if (roll < 19) return PAT_ZEROS;
    return PAT_ONES;
  endfunction

  // Stops offering items and waits until every data set sent so far has
  // produced its result, then lets the pipeline settle. The checker's count
  // is registered, so the task waits for a clock edge before its first look.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The dictionary length may only change with nothing in flight.
  task automatic write_dictionary(input logic [DICT_W-1:0] value);
    drain_results();
    cfg_ch.valid             <= 1'b1;
    cfg_ch.dictionary_blocks <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side. Modes switch after a random span: always ready, mostly
  // ready, coin flip and mostly stalled. On request it holds off for a long
  // stretch so that results pile up and the block stalls its input.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned n;
    out_ch.ready <= 1'b0;
    hold_active = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_active  = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      for (n = 0; n < span && !hold_off_req; n++) begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned dict;
    int unsigned blocks;
    int unsigned tail;
    int unsigned length;
    rst_n                    <= 1'b0;
    in_ch.valid              <= 1'b0;
    in_ch.sample             <= '0;
    in_ch.last_sample        <= 1'b0;
    cfg_ch.valid             <= 1'b0;
    cfg_ch.dictionary_blocks <= '0;
    hold_off_req = 1'b0;
    burst_left   = 0;
    random_items = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the dictionary length from reset: a data set with no complete
    // block at all, then one block followed by a single dropped bit. Both
    // have too few blocks. The samples walk through the byte extremes.
    send_sample(8'hFF, 1'b1);
    send_sample(8'h00, 1'b0);
    send_sample(8'hFF, 1'b0);
    send_sample(8'h01, 1'b0);
    send_sample(8'hFE, 1'b0);
    send_sample(8'h80, 1'b0);
    send_sample(8'h7F, 1'b0);
    send_sample(8'h55, 1'b1);

    // Empty dictionary: every block is tested, and a block value seen for
    // the first time measures its distance from position zero.
    write_dictionary('0);
    for (i = 0; i < BLOCK_BITS_DEF; i++) send_sample(8'h01, i == BLOCK_BITS_DEF - 1);

    // Dictionary of one with exactly one block: still too few.
    write_dictionary(16'd1);
    send_dataset(BLOCK_BITS_DEF, PAT_RANDOM);

    // Largest dictionary: any data set that fits in the run is too short.
    write_dictionary('1);
    send_sample(8'hAA, 1'b1);

    // Back pressure: the result side holds off while the sender keeps
    // offering tiny data sets, each of which closes with a result.
    write_dictionary('0);
    hold_off_req = 1'b1;
    wait (hold_active);
    repeat (PRESSURE_SETS) send_dataset($urandom_range(1, 3), pick_pattern());

    // Random phases: a dictionary length, then a few data sets. Small
    // dictionaries get sets close to the too-few boundary or somewhat past
    // it; large ones only get short sets.
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       dict = 0;
        1:       dict = 1;
        2, 3:    dict = $urandom_range(2, 8);
        4, 5:    dict = $urandom_range(9, 30);
        6:       dict = $urandom_range(0, 3);
        default: dict = ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(1000, 65534);
      endcase
      write_dictionary(dict[DICT_W-1:0]);
      repeat ($urandom_range(1, 3)) begin
        if (dict > 60) begin
          blocks = $urandom_range(0, 12);
        end else if ($urandom_range(0, 2) == 0) begin
          blocks = $urandom_range(0, dict + 1);
        end else begin
          blocks = dict + $urandom_range(1, 20);
        end
        tail   = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, BLOCK_BITS_DEF - 1);
        length = BLOCK_BITS_DEF * blocks + tail;
        if (length == 0) length = 1;
        send_dataset(length, pick_pattern());
        random_items += length;
      end
    end

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
